// ===== rtl/core/wpmq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package wpmq_pkg;

  // Sizes of the point fields, the queue and the result.
  localparam int unsigned COORD_BITS  = 24;
  localparam int unsigned VAL_BITS    = COORD_BITS + 2;
  localparam int unsigned BEST_BITS   = COORD_BITS + 2;
  localparam int unsigned SUM_BITS    = COORD_BITS + 3;
  localparam int unsigned QUEUE_DEPTH = 64;

  // One queue entry: y - x of a point and its x.
  typedef struct packed {
    logic signed [VAL_BITS-1:0] val;
    logic [COORD_BITS-1:0]      x;
  } entry_t;

  // What every cell of the chain does in the current cycle.
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_CLEAR,
    CELL_SHIFT,
    CELL_PUSH
  } cell_op_e;

  // Broadcast from the controller to all cells.
  typedef struct packed {
    cell_op_e op;
    entry_t   entry;
  } cell_ctrl_t;

  // Controller state.
  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

endpackage

`default_nettype wire

// ===== rtl/core/wpmq_point_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface wpmq_point_if;
  import wpmq_pkg::*;

  logic                         valid;
  logic                         ready;
  logic                         first_point;
  logic [COORD_BITS-1:0]        coord_x;
  logic signed [COORD_BITS-1:0] coord_y;
  logic                         last_point;

  modport source (
    output valid, first_point, coord_x, coord_y, last_point,
    input  ready
  );

  modport sink (
    input  valid, first_point, coord_x, coord_y, last_point,
    output ready
  );

endinterface

`default_nettype wire

// ===== rtl/core/wpmq_result_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface wpmq_result_if;
  import wpmq_pkg::*;

  logic                        valid;
  logic                        ready;
  logic signed [BEST_BITS-1:0] best_value;
  logic                        pair_found;
  logic                        queue_overflow;
  logic                        set_done;

  modport source (
    output valid, best_value, pair_found, queue_overflow, set_done,
    input  ready
  );

  modport sink (
    input  valid, best_value, pair_found, queue_overflow, set_done,
    output ready
  );

endinterface

`default_nettype wire

// ===== rtl/core/wpmq_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module wpmq_cell (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  wpmq_pkg::cell_ctrl_t ctrl_i,
  input  logic                 ovf_i,
  input  logic                 nxt_valid_i,
  input  wpmq_pkg::entry_t     nxt_entry_i,
  input  logic                 prev_kept_i,
  output logic                 valid_o,
  output wpmq_pkg::entry_t     entry_o,
  output logic                 kept_o
);
  import wpmq_pkg::*;

  logic   valid_q, valid_d;
  entry_t entry_q, entry_d;

  // The entry survives the back pops when its value beats the new one.
  // Values fall strictly from front to back, so the kept cells form a prefix.
  assign kept_o = valid_q && (entry_q.val > ctrl_i.entry.val);

  // Next contents of the cell.
  always_comb begin
    valid_d = valid_q;
    entry_d = entry_q;
    unique case (ctrl_i.op)
      CELL_HOLD: begin
      end
      CELL_CLEAR: begin
        valid_d = 1'b0;
      end
      CELL_SHIFT: begin
        valid_d = nxt_valid_i;
        entry_d = nxt_entry_i;
      end
      CELL_PUSH: begin
        if (ovf_i) begin
          // Queue full: everything moves one place toward the front.
          valid_d = 1'b1;
          entry_d = nxt_entry_i;
        end else if (kept_o) begin
          valid_d = 1'b1;
        end else if (prev_kept_i) begin
          // First free place behind the kept entries takes the new point.
          valid_d = 1'b1;
          entry_d = ctrl_i.entry;
        end else begin
          valid_d = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  // Valid bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Entry payload.
  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign valid_o = valid_q;
  assign entry_o = entry_q;

endmodule

`default_nettype wire

// ===== rtl/core/windowed_pair_max_monotonic_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Windowed pair maximum over a stream of points.
// Points enter on the point channel (valid/ready); each request carries
// first_point, coord_x, coord_y and last_point. Each point gives exactly one
// request on the result channel with the running best, the found flag, the
// sticky overflow flag and set_done echoing last_point.
// The user must write the window width through cfg_we_i / cfg_wdata_i
// only while idle; the block itself does not enforce it. The queue is a
// chain of QUEUE_DEPTH cells, front at cell 0. After acceptance the front
// cell is tested and shifted out once per cycle while it lies outside the
// window; then back pops, the push and a full queue are handled together
// across all cells and the result is registered. Each entry expires at
// most once. A new point is taken only when the previous one has
// finished; a finished result waits in the output register, and a stalled
// receiver holds the next point in its last cycle until the register frees.
// Reset empties the queue, clears best, found and overflow, and zeroes the
// window width.
module windowed_pair_max_monotonic_queue (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [wpmq_pkg::COORD_BITS-1:0] cfg_wdata_i,
  wpmq_point_if.sink                     point,
  wpmq_result_if.source                  result
);
  import wpmq_pkg::*;

  state_e state_q, state_d;

  logic [COORD_BITS-1:0]        win_q;
  logic [COORD_BITS-1:0]        x_q;
  logic signed [COORD_BITS-1:0] y_q;
  logic                         last_q;

  logic signed [SUM_BITS-1:0] best_q, best_d;
  logic                       found_q, found_d;
  logic                       ovf_flag_q, ovf_flag_d;

  logic                        out_valid_q;
  logic signed [BEST_BITS-1:0] out_best_q;
  logic                        out_found_q, out_ovf_q, out_done_q;
  logic                        out_load;

  cell_ctrl_t ctrl;
  logic       chain_full;

  logic   cell_valid [QUEUE_DEPTH];
  entry_t cell_entry [QUEUE_DEPTH];
  logic   cell_kept  [QUEUE_DEPTH];

  logic signed [COORD_BITS:0]   x_gap;
  logic                         front_expired;
  logic signed [SUM_BITS-1:0]   cand;
  logic signed [VAL_BITS-1:0]   new_val;
  logic                         in_accept;
  logic                         out_free;

  // Handshake qualifiers.
  assign in_accept = point.valid && point.ready;
  assign out_free  = !out_valid_q || result.ready;
  assign point.ready = (state_q == ST_IDLE);

  // Window test of the front entry and the candidate pair value.
  assign x_gap = $signed({1'b0, x_q}) - $signed({1'b0, cell_entry[0].x});
  assign front_expired = cell_valid[0] && (x_gap > $signed({1'b0, win_q}));
  assign cand = SUM_BITS'(cell_entry[0].val) + $signed({3'b000, x_q})
              + SUM_BITS'(y_q);
  assign new_val = VAL_BITS'(y_q) - $signed({2'b00, x_q});

  // All cells survive the back pops: the push then drops the front.
  assign chain_full = cell_kept[QUEUE_DEPTH-1];

  // Next state, cell command and flag updates.
  always_comb begin
    state_d     = state_q;
    best_d      = best_q;
    found_d     = found_q;
    ovf_flag_d  = ovf_flag_q;
    out_load    = 1'b0;
    ctrl.op     = CELL_HOLD;
    ctrl.entry  = '{val: new_val, x: x_q};
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          state_d = ST_RUN;
          if (point.first_point) begin
            ctrl.op    = CELL_CLEAR;
            best_d     = '0;
            found_d    = 1'b0;
            ovf_flag_d = 1'b0;
          end
        end
      end
      ST_RUN: begin
        if (front_expired) begin
          ctrl.op = CELL_SHIFT;
        end else if (out_free) begin
          ctrl.op  = CELL_PUSH;
          out_load = 1'b1;
          state_d  = ST_IDLE;
          if (cell_valid[0]) begin
            found_d = 1'b1;
            if (!found_q || (cand > best_q)) begin
              best_d = cand;
            end
          end
          if (chain_full) begin
            ovf_flag_d = 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // The chain of queue cells.
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic   nxt_valid;
    entry_t nxt_entry;
    logic   prev_kept;

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign nxt_valid = 1'b0;
      assign nxt_entry = ctrl.entry;
    end else begin : g_mid
      assign nxt_valid = cell_valid[i+1];
      assign nxt_entry = cell_entry[i+1];
    end

    if (i == 0) begin : g_front
      assign prev_kept = 1'b1;
    end else begin : g_rest
      assign prev_kept = cell_kept[i-1];
    end

    wpmq_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .ovf_i       (chain_full),
      .nxt_valid_i (nxt_valid),
      .nxt_entry_i (nxt_entry),
      .prev_kept_i (prev_kept),
      .valid_o     (cell_valid[i]),
      .entry_o     (cell_entry[i]),
      .kept_o      (cell_kept[i])
    );
  end

  // Control state, window register and set flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      win_q       <= '0;
      best_q      <= '0;
      found_q     <= 1'b0;
      ovf_flag_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      best_q     <= best_d;
      found_q    <= found_d;
      ovf_flag_q <= ovf_flag_d;
      if (cfg_we_i) begin
        win_q <= cfg_wdata_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (result.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Point being worked on and the result payload.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      x_q    <= point.coord_x;
      y_q    <= point.coord_y;
      last_q <= point.last_point;
    end
    if (out_load) begin
      out_best_q  <= found_d ? best_d[BEST_BITS-1:0] : '0;
      out_found_q <= found_d;
      out_ovf_q   <= ovf_flag_d;
      out_done_q  <= last_q;
    end
  end

  assign result.valid          = out_valid_q;
  assign result.best_value     = out_best_q;
  assign result.pair_found     = out_found_q;
  assign result.queue_overflow = out_ovf_q;
  assign result.set_done       = out_done_q;

endmodule

`default_nettype wire
